/* sv/idw_pkg.sv */
// ----------------------------------------------------------------------------
// idw_pkg
// Shared types, phase codes and constants of the display write master.
// ----------------------------------------------------------------------------
package idw_pkg;

	// bus phase codes
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_START_A  = 4'd1;
	localparam logic [3:0] PH_START_B  = 4'd2;
	localparam logic [3:0] PH_BIT_LOW  = 4'd3;
	localparam logic [3:0] PH_BIT_HIGH = 4'd4;
	localparam logic [3:0] PH_ACK_LOW  = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH = 4'd6;
	localparam logic [3:0] PH_STOP_A   = 4'd7;
	localparam logic [3:0] PH_STOP_B   = 4'd8;

	// request kinds
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_CMD   = 2'd1;
	localparam logic [1:0] OP_DATA  = 2'd2;
	localparam logic [1:0] OP_PROBE = 2'd3;

	// register indexes
	localparam logic REG_HALF_BIT_TICKS      = 1'b0;
	localparam logic REG_SLAVE_WRITE_ADDRESS = 1'b1;

	localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd4;
	localparam logic [7:0]  SLAVE_ADDR_RST     = 8'h78;
	localparam logic [7:0]  CTRL_CMD           = 8'h00;
	localparam logic [7:0]  CTRL_DATA          = 8'h40;

	typedef struct packed {
		logic [3:0] phase;
		logic [1:0] byte_index;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [1:0] request_kind;
		logic [7:0] payload;
		logic       captured_ack;
	} seq_state_t;

	// packed with scl in the lowest bit
	typedef struct packed {
		logic rejected;
		logic ack;
		logic ack_valid;
		logic done_res;
		logic busy_res;
		logic sda_drive;
		logic sda_level;
		logic scl;
	} result_t;

	// byte sent at a given position of the transaction
	function automatic logic [7:0] byte_for(
		input logic [1:0] idx,
		input logic [1:0] kind,
		input logic [7:0] payload,
		input logic [7:0] slave_addr
	);
		logic [7:0] b;
		if (idx == 2'd0) begin
			b = (kind == OP_PROBE) ? {payload[6:0], 1'b0} : slave_addr;
		end else if (idx == 2'd1) begin
			b = (kind == OP_DATA) ? CTRL_DATA : CTRL_CMD;
		end else begin
			b = payload;
		end
		return b;
	endfunction

endpackage

/* sv/i2c_display_write_master.sv */
// ----------------------------------------------------------------------------
// i2c_display_write_master
// Bit-level I2C write master for a display controller. Every input
// transaction is one bus tick and returns exactly one result transaction
// with the scl and sda levels for that tick plus busy, done, probe acknowledge
// and reject flags. A tick may carry a command write, a data write or an
// address probe; a request that arrives while a bus transfer runs is dropped
// and flagged. One transaction is taken every clock cycle; its result appears
// in the next cycle from the output register, and a stalled output holds the
// input only once that register is full and not being taken. Each bus phase
// lasts half_bit_ticks ticks (zero acts as one).
// ----------------------------------------------------------------------------
module i2c_display_write_master #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // value[7:0], sda_in[8], zero fill
	input  logic [1:0]  s_tuser,   // op[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // scl, sda_level, sda_drive, busy_res,
	                               // done_res, ack_valid, ack, rejected
);

	logic [15:0]             half_bit_ticks_q;
	logic [7:0]              slave_addr_q;
	idw_pkg::seq_state_t     state_q;
	idw_pkg::seq_state_t     state_nxt;
	logic [DELAY_WIDTH-1:0]  tick_q;
	logic [DELAY_WIDTH-1:0]  tick_nxt;
	idw_pkg::result_t        res;
	logic                    can_load;
	logic                    accept;

	assign s_tready = can_load;
	assign accept   = s_tvalid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_ticks_q <= idw_pkg::HALF_BIT_TICKS_RST;
			slave_addr_q     <= idw_pkg::SLAVE_ADDR_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				idw_pkg::REG_HALF_BIT_TICKS:      half_bit_ticks_q <= cfg_wdata;
				idw_pkg::REG_SLAVE_WRITE_ADDRESS: slave_addr_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= idw_pkg::PH_IDLE;
			state_q.byte_index   <= 2'd0;
			state_q.bit_count    <= 4'd0;
			state_q.shift_byte   <= 8'd0;
			state_q.request_kind <= idw_pkg::OP_TICK;
			state_q.payload      <= 8'd0;
			state_q.captured_ack <= 1'b1;
			tick_q               <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
			tick_q  <= tick_nxt;
		end
	end

	idw_step #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_step (
		.cur                 (state_q),
		.tick_cur            (tick_q),
		.op                  (s_tuser),
		.value               (s_tdata[7:0]),
		.sda_in              (s_tdata[8]),
		.half_bit_ticks      (half_bit_ticks_q),
		.slave_write_address (slave_addr_q),
		.nxt                 (state_nxt),
		.tick_nxt            (tick_nxt),
		.res                 (res)
	);

	idw_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s_tvalid),
		.din      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* sv/idw_step.sv */
// ----------------------------------------------------------------------------
// idw_step
// Next-state and bus-level logic for one tick of the write sequencer.
// ----------------------------------------------------------------------------
module idw_step #(
	parameter int DELAY_WIDTH = 16
) (
	input  idw_pkg::seq_state_t     cur,
	input  logic [DELAY_WIDTH-1:0]  tick_cur,
	input  logic [1:0]              op,
	input  logic [7:0]              value,
	input  logic                    sda_in,
	input  logic [15:0]             half_bit_ticks,
	input  logic [7:0]              slave_write_address,
	output idw_pkg::seq_state_t     nxt,
	output logic [DELAY_WIDTH-1:0]  tick_nxt,
	output idw_pkg::result_t        res
);

	localparam int CW = (DELAY_WIDTH + 1 > 17) ? DELAY_WIDTH + 1 : 17;

	logic [CW-1:0] len;
	logic [CW-1:0] h_ext;
	logic [CW-1:0] cap;

	// phase length: zero acts as one, capped at the counter range
	always_comb begin
		h_ext = CW'(half_bit_ticks);
		if (half_bit_ticks == 16'd0) begin
			h_ext = CW'(1);
		end
		cap = CW'(1) << DELAY_WIDTH;
		len = (h_ext > cap) ? cap : h_ext;
	end

	always_comb begin
		idw_pkg::seq_state_t st;
		logic [DELAY_WIDTH-1:0] tick;
		logic [CW-1:0]          tick_inc;
		logic                   phase_end;
		logic [3:0]             bc;

		st   = cur;
		tick = tick_cur;
		res  = '0;
		res.scl       = 1'b1;
		res.sda_level = 1'b1;
		res.sda_drive = 1'b1;

		if (st.phase > idw_pkg::PH_STOP_B) begin
			st.phase = idw_pkg::PH_IDLE;
		end

		if (op != idw_pkg::OP_TICK) begin
			if (st.phase != idw_pkg::PH_IDLE) begin
				res.rejected = 1'b1;
			end else begin
				st.request_kind = op;
				st.payload      = value;
				st.byte_index   = 2'd0;
				st.bit_count    = 4'd0;
				tick            = '0;
				st.phase        = idw_pkg::PH_START_A;
			end
		end

		tick_inc  = CW'(tick) + CW'(1);
		phase_end = tick_inc >= len;
		bc        = st.bit_count + 4'd1;

		if (st.phase != idw_pkg::PH_IDLE) begin
			res.busy_res = 1'b1;
			unique case (st.phase)
				idw_pkg::PH_START_A: begin
					res.sda_level = 1'b1;
				end
				idw_pkg::PH_START_B: begin
					res.sda_level = 1'b0;
				end
				idw_pkg::PH_BIT_LOW: begin
					res.scl       = 1'b0;
					res.sda_level = st.shift_byte[7];
				end
				idw_pkg::PH_BIT_HIGH: begin
					res.sda_level = st.shift_byte[7];
				end
				idw_pkg::PH_ACK_LOW: begin
					res.scl       = 1'b0;
					res.sda_drive = 1'b0;
				end
				idw_pkg::PH_ACK_HIGH: begin
					res.sda_drive = 1'b0;
					// sample on the first tick of the high half
					if (tick == '0) begin
						st.captured_ack = sda_in;
					end
				end
				idw_pkg::PH_STOP_A: begin
					res.scl       = 1'b0;
					res.sda_level = 1'b0;
				end
				default: begin
				end
			endcase

			if (!phase_end) begin
				tick = tick_inc[DELAY_WIDTH-1:0];
			end else begin
				tick = '0;
				unique case (st.phase)
					idw_pkg::PH_START_A: begin
						st.phase = idw_pkg::PH_START_B;
					end
					idw_pkg::PH_START_B: begin
						st.byte_index = 2'd0;
						st.shift_byte = idw_pkg::byte_for(2'd0, st.request_kind,
							st.payload, slave_write_address);
						st.bit_count  = 4'd0;
						st.phase      = idw_pkg::PH_BIT_LOW;
					end
					idw_pkg::PH_BIT_LOW: begin
						st.phase = idw_pkg::PH_BIT_HIGH;
					end
					idw_pkg::PH_BIT_HIGH: begin
						st.shift_byte = {st.shift_byte[6:0], 1'b0};
						st.bit_count  = bc;
						st.phase = (bc >= 4'd8) ? idw_pkg::PH_ACK_LOW
						                        : idw_pkg::PH_BIT_LOW;
					end
					idw_pkg::PH_ACK_LOW: begin
						st.phase = idw_pkg::PH_ACK_HIGH;
					end
					idw_pkg::PH_ACK_HIGH: begin
						if (st.request_kind == idw_pkg::OP_PROBE || st.byte_index >= 2'd2) begin
							st.phase = idw_pkg::PH_STOP_A;
						end else begin
							st.byte_index = st.byte_index + 2'd1;
							st.shift_byte = idw_pkg::byte_for(st.byte_index,
								st.request_kind, st.payload, slave_write_address);
							st.bit_count  = 4'd0;
							st.phase      = idw_pkg::PH_BIT_LOW;
						end
					end
					idw_pkg::PH_STOP_A: begin
						st.phase = idw_pkg::PH_STOP_B;
					end
					default: begin
						res.done_res = 1'b1;
						if (st.request_kind == idw_pkg::OP_PROBE) begin
							res.ack_valid = 1'b1;
							res.ack       = st.captured_ack;
						end
						st.phase = idw_pkg::PH_IDLE;
					end
				endcase
			end
		end

		nxt      = st;
		tick_nxt = tick;
	end

endmodule

/* sv/idw_obuf.sv */
// ----------------------------------------------------------------------------
// idw_obuf
// Result register between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module idw_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  idw_pkg::result_t din,
	output logic             can_load,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata
);

	logic             valid_q;
	idw_pkg::result_t data_q;

	// a new result may enter when the register is empty or being drained
	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= din;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule
